@@ rtl/core/sha_pkg.sv @@
// Package for the SHA-256 message hasher: types, constants, round functions.
`default_nettype none
package sha_pkg;

  localparam int WORD_W = 32;
  localparam int BLK_DEPTH = 16;
  localparam int CV_DEPTH = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE_RD,
    ST_BYTE_WR,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_CV_LOAD,
    ST_ROUND,
    ST_ROUND_LAST,
    ST_CV_ADD,
    ST_EMIT
  } state_t;

  // what follows a compression
  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_LEN
  } after_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sha_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/sha_round.sv @@
// Compression datapath: rolling 16-word schedule window and round variables.
`default_nettype none
module sha_round (
  input  wire logic        clk,
  input  wire logic        load_w,
  input  wire logic [31:0] w_in,
  input  wire logic        load_v,
  input  wire logic [31:0] v_in,
  input  wire logic        step,
  input  wire logic [5:0]  rnd,
  input  wire logic [2:0]  rd_idx,
  output logic      [31:0] v_out
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] w_new, t1, t2;

  always_comb begin
    w_new = sha_pkg::ssig1(w[14]) + w[9] + sha_pkg::ssig0(w[1]) + w[0];
    t1 = v[7] + sha_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha_pkg::ROUND_K[rnd] + w[0];
    t2 = sha_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign v_out = v[rd_idx];

  // window shifts one word per round; w[0] is the word for the current round
  always_ff @(posedge clk) begin
    if (load_w || step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= load_w ? w_in : w_new;
    end
    // loads go in order 0..7 through the shift
    if (load_v) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= v_in;
    end else if (step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sha256_message_hasher.sv @@
// Top level of the streaming SHA-256 message hasher.
`default_nettype none
// Streaming SHA-256. At most one message byte per input transaction; a
// transaction with last_byte set pads the message and returns the eight
// digest words as eight output transactions, then the hasher restarts.
// Block words live in a 16x32 RAM (read-modify-write per byte), chaining
// words in an 8x32 RAM. Each byte is accepted, read and written back before
// the next is taken. A full block is then compressed: the schedule window
// and round variables are loaded, 64 rounds run at one per cycle, then a
// settle state and the chain update follow. Finishing adds zero fill, the
// two length words, one or two compressions and the output (each digest
// word is read, then offered until taken, so an output stall holds it).
module sha256_message_hasher (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sha_pkg::in_item_t in_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output sha_pkg::out_item_t     out_data,
  output logic                   out_valid,
  input  wire logic              out_ready
);

  localparam int BA = $clog2(sha_pkg::BLK_DEPTH);
  localparam int CA = $clog2(sha_pkg::CV_DEPTH);

  sha_pkg::state_t state, state_next;
  sha_pkg::in_item_t item;
  logic [63:0] message_bits;
  logic [5:0]  fill_position;
  logic [6:0]  cnt;
  logic        fin, pad_two, cv_valid;
  sha_pkg::after_t after;

  logic          b_we;
  logic [BA-1:0] b_wa, b_ra;
  logic [31:0]   b_wd, b_rd;
  logic          c_we;
  logic [CA-1:0] c_wa, c_ra;
  logic [31:0]   c_wd, c_rd, c_val;
  logic [2:0]    iv_idx;
  logic          load_w, load_v, step;
  logic [31:0]   v_out;

  sha_ram #(.WIDTH(sha_pkg::WORD_W), .DEPTH(sha_pkg::BLK_DEPTH)) u_blk (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  sha_ram #(.WIDTH(sha_pkg::WORD_W), .DEPTH(sha_pkg::CV_DEPTH)) u_cv (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

  sha_round u_round (
    .clk(clk), .load_w(load_w), .w_in(b_rd), .load_v(load_v),
    .v_in(c_val), .step(step), .rnd(cnt[5:0]), .rd_idx(cnt[3:1]), .v_out(v_out));

  // chain RAM reads as the initial values until the first compression writes it
  assign iv_idx = (state == sha_pkg::ST_CV_ADD) ? cnt[3:1] : cnt[2:0] - 3'd1;
  assign c_val = cv_valid ? c_rd : sha_pkg::INIT_HASH[iv_idx];

  logic [1:0]  bsel;
  logic [31:0] bmask, bval;
  always_comb begin
    bsel  = fill_position[1:0];
    bmask = 32'hff << ((3 - bsel) * 8);
    bval  = {24'd0, (fin ? sha_pkg::PAD_BYTE : item.data_byte)} << ((3 - bsel) * 8);
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    b_we = 1'b0; b_wa = fill_position[5:2]; b_wd = (b_rd & ~bmask) | bval;
    b_ra = fill_position[5:2];
    c_we = 1'b0; c_wa = cnt[CA-1:0]; c_wd = c_val + v_out; c_ra = cnt[CA-1:0];
    load_w = 1'b0; load_v = 1'b0; step = 1'b0;
    out_valid = 1'b0;
    out_data.digest_word = c_rd;
    out_data.word_number = cnt[2:0];
    out_data.final_word  = (cnt[2:0] == 3'd7);
    case (state)
      sha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.byte_present) state_next = sha_pkg::ST_BYTE_RD;
          else if (in_data.last_byte) state_next = sha_pkg::ST_BYTE_RD;
        end
      end
      sha_pkg::ST_BYTE_RD: state_next = sha_pkg::ST_BYTE_WR;
      sha_pkg::ST_BYTE_WR: begin
        b_we = 1'b1;
        if (fin) b_wd = b_rd & ~(32'hffffffff >> (bsel * 8)) | bval;
        if (fin) state_next = sha_pkg::ST_PAD;
        else if (fill_position == 6'd63) state_next = sha_pkg::ST_CV_LOAD;
        else if (item.last_byte) state_next = sha_pkg::ST_BYTE_RD;
        else state_next = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_PAD: begin
        // zero the words after the pad byte's word (all, in a second block)
        b_we = 1'b1; b_wa = cnt[BA-1:0]; b_wd = '0;
        if (!pad_two && cnt[3:0] == 4'd14) state_next = sha_pkg::ST_LEN_HI;
        else if (cnt[3:0] == 4'd15) state_next = sha_pkg::ST_CV_LOAD;
        if (cnt[3:0] <= fill_position[5:2] && !(after == sha_pkg::AFT_LEN)) b_we = 1'b0;
      end
      sha_pkg::ST_LEN_HI: begin
        b_we = 1'b1; b_wa = 4'd14; b_wd = message_bits[63:32];
        state_next = sha_pkg::ST_LEN_LO;
      end
      sha_pkg::ST_LEN_LO: begin
        b_we = 1'b1; b_wa = 4'd15; b_wd = message_bits[31:0];
        state_next = sha_pkg::ST_CV_LOAD;
      end
      sha_pkg::ST_CV_LOAD: begin
        // cnt 1..16: block words into window; 1..8: chain words into vars
        b_ra = cnt[BA-1:0];
        c_ra = cnt[CA-1:0];
        load_w = (cnt != 7'd0) && (cnt <= 7'd16);
        load_v = (cnt != 7'd0) && (cnt <= 7'd8);
        if (cnt == 7'd16) state_next = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        step = 1'b1;
        if (cnt == 7'd63) state_next = sha_pkg::ST_ROUND_LAST;
      end
      sha_pkg::ST_ROUND_LAST: state_next = sha_pkg::ST_CV_ADD;
      sha_pkg::ST_CV_ADD: begin
        // read addr at even cnt, write at odd
        c_ra = cnt[3:1]; c_wa = cnt[3:1];
        c_we = cnt[0];
        if (cnt == 7'd15) begin
          if (after == sha_pkg::AFT_IDLE) state_next = sha_pkg::ST_IDLE;
          // a last byte that filled the block still needs its pad byte
          else if (after == sha_pkg::AFT_PAD)
            state_next = pad_two ? sha_pkg::ST_PAD : sha_pkg::ST_BYTE_RD;
          else state_next = sha_pkg::ST_EMIT;
        end
      end
      sha_pkg::ST_EMIT: begin
        c_ra = cnt[2:0];
        out_valid = cnt[3];
        if (out_valid && out_ready && cnt[2:0] == 3'd7) state_next = sha_pkg::ST_IDLE;
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      message_bits <= '0; fill_position <= '0; cnt <= '0;
      fin <= 1'b0; pad_two <= 1'b0; cv_valid <= 1'b0; after <= sha_pkg::AFT_IDLE;
    end else begin
      state <= state_next;
      case (state)
        sha_pkg::ST_IDLE: begin
          cnt <= '0;
          if (in_valid && (in_data.byte_present || in_data.last_byte)) begin
            item <= in_data;
            fin <= !in_data.byte_present;
          end
        end
        sha_pkg::ST_BYTE_WR: begin
          cnt <= '0;
          if (fin) begin
            pad_two <= fill_position >= 6'd56;
            after <= (fill_position >= 6'd56) ? sha_pkg::AFT_PAD : sha_pkg::AFT_LEN;
            cnt <= {3'd0, fill_position[5:2] + 4'd1};
          end else begin
            message_bits <= message_bits + 64'd8;
            fill_position <= fill_position + 6'd1;
            after <= sha_pkg::AFT_IDLE;
            if (item.last_byte && fill_position != 6'd63) fin <= 1'b1;
            if (item.last_byte && fill_position == 6'd63) begin
              // pad goes in a fresh block after this compression
              fin <= 1'b1;
              after <= sha_pkg::AFT_PAD;
            end
          end
        end
        sha_pkg::ST_PAD: begin
          cnt <= cnt + 7'd1;
          if (state_next != sha_pkg::ST_PAD) cnt <= '0;
        end
        sha_pkg::ST_CV_LOAD: begin
          cnt <= (cnt == 7'd16) ? 7'd0 : cnt + 7'd1;
        end
        sha_pkg::ST_ROUND: cnt <= cnt + 7'd1;
        sha_pkg::ST_ROUND_LAST: cnt <= '0;
        sha_pkg::ST_CV_ADD: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd15) begin
            cv_valid <= 1'b1;
            cnt <= '0;
            if (after == sha_pkg::AFT_PAD) begin
              after <= sha_pkg::AFT_LEN; pad_two <= 1'b0;
            end
          end
        end
        sha_pkg::ST_EMIT: begin
          if (!cnt[3]) cnt <= {3'd0, 1'b1, cnt[2:0]};
          else if (out_ready) begin
            cnt <= {4'd0, cnt[2:0] + 3'd1};
            if (cnt[2:0] == 3'd7) begin
              message_bits <= '0; fill_position <= '0; fin <= 1'b0;
              cv_valid <= 1'b0; after <= sha_pkg::AFT_IDLE; cnt <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == sha_pkg::ST_EMIT)
    else $error("output valid outside emit");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while digest pending");
  assert property (@(posedge clk) disable iff (rst)
    step |-> !load_w)
    else $error("schedule load during rounds");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.final_word) |=> state == sha_pkg::ST_IDLE)
    else $error("no restart after final word");

endmodule
`default_nettype wire

@@ tb/sha256_message_hasher_tb.sv @@
// Testbench for the streaming SHA-256 hasher: byte messages in, digest words checked.
`timescale 1ns / 1ps
module sha256_message_hasher_tb;

  localparam int CYCLE_LIMIT = 2000000;

  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [63:0] msg_bits;
    logic [5:0]  fill;
    sha_pkg::out_item_t pending [$];
    int          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      msg_bits = '0;
      fill = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      v = chain;
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[r] + w[r];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void put(int pos, logic [7:0] b);
      blk[pos/4][(3 - pos%4)*8 +: 8] = b;
    endfunction

    function void note_input(sha_pkg::in_item_t t);
      int p;
      sha_pkg::out_item_t o;
      if (t.byte_present) begin
        put(int'(fill), t.data_byte);
        msg_bits += 64'd8;
        fill++;
        if (fill == 0) compress();
      end
      if (!t.last_byte) return;
      p = int'(fill);
      put(p, 8'h80);
      for (int i = p + 1; i < 64; i++) put(i, 8'h00);
      if (p >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = msg_bits[63:32];
      blk[15] = msg_bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain[i];
        o.word_number = 3'(i);
        o.final_word = (i == 7);
        pending.push_back(o);
      end
      restart();
    endfunction

    function void check_result(sha_pkg::out_item_t got);
      sha_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got.digest_word !== exp.digest_word || got.word_number !== exp.word_number ||
          got.final_word !== exp.final_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", exp.digest_word,
                   exp.word_number, exp.final_word, got.digest_word,
                   got.word_number, got.final_word);
      end
    endfunction
  endclass

  logic clk, rst;
  sha_pkg::in_item_t in_data;
  logic in_valid, in_ready;
  sha_pkg::out_item_t out_data;
  logic out_valid, out_ready;
  int cycles = 0;
  int n_sent = 0;
  bit quiet_sink;
  digest_scoreboard sb;

  sha256_message_hasher u_dut (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    quiet_sink = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls per transaction, occasional stall-free stretches.
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = quiet_sink ? 0 : $urandom_range(0, 14);
      if (w == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
        out_ready <= 1'b1;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  task automatic send(logic [7:0] b, logic pres, logic lst, bit gaps);
    int w;
    sha_pkg::in_item_t t;
    w = gaps ? $urandom_range(0, 14) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    t.data_byte = b;
    t.byte_present = pres;
    t.last_byte = lst;
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(t);
    n_sent++;
  endtask

  task automatic send_message(int len, bit gaps);
    bit bare;
    bare = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send(8'($urandom), 1'b0, 1'b0, gaps);
      send(8'($urandom), 1'b1, (!bare && i == len - 1), gaps);
    end
    if (bare) send(8'($urandom), 1'b0, 1'b1, gaps);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int len;
    @(negedge rst);
    @(posedge clk);
    // Directed: empty message, one-byte extremes, idle item, byte with last.
    send(8'h00, 1'b0, 1'b1, 1'b0);
    send(8'hff, 1'b0, 1'b0, 1'b1);
    send(8'h00, 1'b1, 1'b1, 1'b0);
    send(8'hff, 1'b1, 1'b1, 1'b1);
    send(8'h61, 1'b1, 1'b0, 1'b0);
    send(8'h62, 1'b1, 1'b0, 1'b0);
    send(8'h63, 1'b0, 1'b0, 1'b0);
    send(8'h63, 1'b1, 1'b1, 1'b0);
    drain();
    // Pad boundaries: 55/56/63 bytes, 64-byte full block; last byte or bare finish.
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(64, 1'b0);
    quiet_sink = 1'b1;
    send_message(63, 1'b0);
    quiet_sink = 1'b0;
    drain();
    while (n_sent < 470) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(50, 70);
        2: len = $urandom_range(0, 140);
        default: len = $urandom_range(1, 30);
      endcase
      send_message(len, $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sha_pkg.sv
rtl/core/sha_ram.sv
rtl/core/sha_round.sv
rtl/core/sha256_message_hasher.sv
tb/sha256_message_hasher_tb.sv
